// File: rtl/vna_pkg.sv
// Shared constants, codes and types of the vertex normal accumulator.
package vna_pkg;

	localparam int MAX_POINTS_DEF = 1024;
	localparam int IDX_W = 10;
	localparam int CRD_W = 16;
	localparam int EDG_W = 17;
	localparam int PRD_W = 34;
	localparam int CRS_W = 35;
	localparam int ACC_W = 48;
	localparam int NRM_W = 16;
	localparam int ML_W = 16;
	localparam int S_DATA_W = 80;
	localparam int M_DATA_W = 64;

	localparam logic signed [NRM_W-1:0] ONE_Q14 = 16'sd16384;

	typedef enum logic [1:0] {
		FUNC_LOAD = 2'd0,
		FUNC_TRI  = 2'd1,
		FUNC_READ = 2'd2
	} func_t;

	typedef struct packed {
		logic signed [NRM_W-1:0] nx;
		logic signed [NRM_W-1:0] ny;
		logic signed [NRM_W-1:0] nz;
		logic                    fallback;
	} nrm_res_t;

	localparam nrm_res_t FALLBACK = '{nx: '0, ny: ONE_Q14, nz: '0, fallback: 1'b1};

endpackage

// File: rtl/vertex_normal_accumulator_unit.sv
// Top level of the vertex normal accumulator: memories, operation sequencer and output register.
//
// Channel   Dir  Beat contents
// s_axis    in   tdata: vertex_a, vertex_b, vertex_c, coord_x, coord_y, coord_z; tuser: func
// m_axis    out  tdata: vertex_index, normal_x, normal_y, normal_z; tuser: used_fallback
// cfg       in   min_length, written whenever cfg_wr_en is high
//
// Loads and triangles are paced by the single port of each memory.
// A read is paced by the square root and the divider, which is shared by the three components in turn.
// After reset a clearing pass over all MAX_POINTS entries zeroes the accumulators before any beat.
// The result register lets the next beat be accepted while a result is still waiting.
module vertex_normal_accumulator_unit #(
	parameter int MAX_POINTS = vna_pkg::MAX_POINTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [vna_pkg::ML_W-1:0]       cfg_wr_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [vna_pkg::S_DATA_W-1:0]   s_tdata,   // vertex_a, vertex_b, vertex_c, x, y, z
	input  logic [1:0]                     s_tuser,   // func
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [vna_pkg::M_DATA_W-1:0]   m_tdata,   // vertex_index, normal_x, y, z
	output logic [0:0]                     m_tuser    // used_fallback
);
	import vna_pkg::*;

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int PAD_W = M_DATA_W - IDX_W - 3*NRM_W;

	typedef enum logic [9:0] {
		ST_CLEAR   = 10'b0000000001,
		ST_IDLE    = 10'b0000000010,
		ST_TRI_RD  = 10'b0000000100,
		ST_CROSS   = 10'b0000001000,
		ST_ACC_RD  = 10'b0000010000,
		ST_ACC_WR  = 10'b0000100000,
		ST_RD_ACC  = 10'b0001000000,
		ST_NORM_GO = 10'b0010000000,
		ST_NORM    = 10'b0100000000,
		ST_OUT     = 10'b1000000000
	} state_t;

	state_t                    state_q;
	logic [AW-1:0]             clr_q;
	logic [1:0]                cnt_q;
	logic [IDX_W-1:0]          va_q;
	logic [IDX_W-1:0]          vb_q;
	logic [IDX_W-1:0]          vc_q;
	logic [3*CRD_W-1:0]        pt_q [3];
	logic signed [PRD_W-1:0]   prod1_q;
	logic signed [PRD_W-1:0]   prod2_q;
	logic signed [CRS_W-1:0]   n_q [3];
	nrm_res_t                  res_q;
	logic [ML_W-1:0]           ml_q;
	logic                      m_tvalid_q;
	logic [M_DATA_W-1:0]       m_tdata_q;
	logic                      m_tuser_q;

	logic [3*CRD_W-1:0]        pt_mem [MAX_POINTS];
	logic [3*CRD_W-1:0]        pt_rdata_q;
	logic [3*ACC_W-1:0]        acc_mem [MAX_POINTS];
	logic [3*ACC_W-1:0]        acc_rdata_q;

	logic                      pt_we;
	logic [AW-1:0]             pt_addr;
	logic                      acc_we;
	logic [AW-1:0]             acc_addr;
	logic [3*ACC_W-1:0]        acc_wdata;
	logic [3*ACC_W-1:0]        acc_sum;

	logic [IDX_W-1:0]          in_va;
	logic [IDX_W-1:0]          in_vb;
	logic [IDX_W-1:0]          in_vc;
	logic                      va_ok;
	logic                      vb_ok;
	logic                      vc_ok;
	logic [IDX_W-1:0]          corner_idx;
	logic signed [EDG_W-1:0]   e1 [3];
	logic signed [EDG_W-1:0]   e2 [3];
	logic signed [EDG_W-1:0]   mul_a1;
	logic signed [EDG_W-1:0]   mul_b1;
	logic signed [EDG_W-1:0]   mul_a2;
	logic signed [EDG_W-1:0]   mul_b2;
	logic                      nrm_start;
	logic                      nrm_done;
	nrm_res_t                  nrm_res;

	function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
			input logic signed [CRS_W-1:0] d);
		logic [ACC_W:0] s;
		s = {a[ACC_W-1], a} + {{(ACC_W+1-CRS_W){d[CRS_W-1]}}, d};
		if (s[ACC_W] != s[ACC_W-1])
			return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		return s[ACC_W-1:0];
	endfunction

	assign in_va = s_tdata[IDX_W-1:0];
	assign in_vb = s_tdata[2*IDX_W-1:IDX_W];
	assign in_vc = s_tdata[3*IDX_W-1:2*IDX_W];
	assign va_ok = int'(in_va) < MAX_POINTS;
	assign vb_ok = int'(in_vb) < MAX_POINTS;
	assign vc_ok = int'(in_vc) < MAX_POINTS;

	always_comb begin
		unique case (cnt_q)
			2'd0:    corner_idx = va_q;
			2'd1:    corner_idx = vb_q;
			default: corner_idx = vc_q;
		endcase
		for (int i = 0; i < 3; i++) begin
			e1[i] = EDG_W'(signed'(pt_q[1][i*CRD_W +: CRD_W]))
				- EDG_W'(signed'(pt_q[0][i*CRD_W +: CRD_W]));
			e2[i] = EDG_W'(signed'(pt_q[2][i*CRD_W +: CRD_W]))
				- EDG_W'(signed'(pt_q[0][i*CRD_W +: CRD_W]));
		end
		unique case (cnt_q)
			2'd0: begin
				mul_a1 = e1[1]; mul_b1 = e2[2]; mul_a2 = e1[2]; mul_b2 = e2[1];
			end
			2'd1: begin
				mul_a1 = e1[2]; mul_b1 = e2[0]; mul_a2 = e1[0]; mul_b2 = e2[2];
			end
			default: begin
				mul_a1 = e1[0]; mul_b1 = e2[1]; mul_a2 = e1[1]; mul_b2 = e2[0];
			end
		endcase
		for (int i = 0; i < 3; i++)
			acc_sum[i*ACC_W +: ACC_W] = sat_add(acc_rdata_q[i*ACC_W +: ACC_W], n_q[i]);
	end

	always_comb begin
		s_tready = (state_q == ST_IDLE);
		pt_we = 1'b0;
		pt_addr = AW'(corner_idx);
		acc_we = 1'b0;
		acc_addr = AW'(corner_idx);
		acc_wdata = '0;
		unique case (state_q)
			ST_CLEAR: begin
				acc_we = 1'b1;
				acc_addr = clr_q;
			end
			ST_IDLE: begin
				pt_addr = AW'(in_va);
				acc_addr = AW'(in_va);
				if (s_tvalid && s_tuser == FUNC_LOAD && va_ok) begin
					pt_we = 1'b1;
					acc_we = 1'b1;
				end
			end
			ST_ACC_WR: begin
				acc_we = 1'b1;
				acc_wdata = acc_sum;
			end
			ST_RD_ACC: acc_addr = AW'(va_q);
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pt_we) pt_mem[pt_addr] <= s_tdata[S_DATA_W-3 : 3*IDX_W];
		pt_rdata_q <= pt_mem[pt_addr];
	end

	always_ff @(posedge clk) begin
		if (acc_we) acc_mem[acc_addr] <= acc_wdata;
		acc_rdata_q <= acc_mem[acc_addr];
	end

	assign nrm_start = (state_q == ST_NORM_GO);

	vna_norm u_norm (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (nrm_start),
		.acc     (acc_rdata_q),
		.min_len (ml_q),
		.done    (nrm_done),
		.res     (nrm_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			cnt_q <= '0;
			va_q <= '0;
			vb_q <= '0;
			vc_q <= '0;
			pt_q <= '{default: '0};
			prod1_q <= '0;
			prod2_q <= '0;
			n_q <= '{default: '0};
			res_q <= FALLBACK;
			ml_q <= ML_W'(1);
			m_tvalid_q <= 1'b0;
			m_tdata_q <= '0;
			m_tuser_q <= 1'b0;
		end else begin
			if (cfg_wr_en) ml_q <= cfg_wr_data;
			if (m_tvalid_q && m_tready && state_q != ST_OUT) m_tvalid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (int'(clr_q) == MAX_POINTS - 1) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						va_q <= in_va;
						vb_q <= in_vb;
						vc_q <= in_vc;
						cnt_q <= '0;
						unique case (s_tuser)
							FUNC_TRI: begin
								if (va_ok && vb_ok && vc_ok) state_q <= ST_TRI_RD;
							end
							FUNC_READ: begin
								if (va_ok) begin
									state_q <= ST_RD_ACC;
								end else begin
									res_q <= FALLBACK;
									state_q <= ST_OUT;
								end
							end
							default: ;
						endcase
					end
				end
				ST_TRI_RD: begin
					if (cnt_q != 2'd0) pt_q[cnt_q - 2'd1] <= pt_rdata_q;
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd3) state_q <= ST_CROSS;
				end
				ST_CROSS: begin
					prod1_q <= mul_a1 * mul_b1;
					prod2_q <= mul_a2 * mul_b2;
					if (cnt_q != 2'd0)
						n_q[cnt_q - 2'd1] <= CRS_W'(prod1_q) - CRS_W'(prod2_q);
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd3) state_q <= ST_ACC_RD;
				end
				ST_ACC_RD: state_q <= ST_ACC_WR;
				ST_ACC_WR: begin
					if (cnt_q == 2'd2) begin
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + 2'd1;
						state_q <= ST_ACC_RD;
					end
				end
				ST_RD_ACC:  state_q <= ST_NORM_GO;
				ST_NORM_GO: state_q <= ST_NORM;
				ST_NORM: begin
					if (nrm_done) begin
						res_q <= nrm_res;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q <= {{PAD_W{1'b0}}, res_q.nz, res_q.ny, res_q.nx, va_q};
						m_tuser_q <= res_q.fallback;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;

endmodule

// File: rtl/vna_norm.sv
// Normalisation unit: threshold test, scaling, square root and division of one accumulator.
module vna_norm (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [3*vna_pkg::ACC_W-1:0]         acc,
	input  logic [vna_pkg::ML_W-1:0]            min_len,
	output logic                                done,
	output vna_pkg::nrm_res_t                   res
);
	import vna_pkg::*;

	typedef enum logic [7:0] {
		N_IDLE  = 8'b00000001,
		N_MAX   = 8'b00000010,
		N_THR   = 8'b00000100,
		N_SHIFT = 8'b00001000,
		N_SUMSQ = 8'b00010000,
		N_SQRT  = 8'b00100000,
		N_DSET  = 8'b01000000,
		N_DIV   = 8'b10000000
	} nstate_t;

	nstate_t          state_q;
	logic [ACC_W-1:0] m_q [3];
	logic [2:0]       neg_q;
	logic [2:0]       k_q;
	logic [63:0]      prod_q;
	logic [63:0]      sum_q;
	logic [63:0]      s_q;
	logic [63:0]      r_q;
	logic [4:0]       j_q;
	logic [46:0]      rem_q;
	logic [45:0]      d_q;
	logic [14:0]      q_q;
	logic [3:0]       i_q;
	logic [1:0]       c_q;
	nrm_res_t         res_q;
	logic             done_q;

	logic [ACC_W-1:0] mx;
	logic [31:0]      mul_op;
	logic [63:0]      sq_bit;
	logic [63:0]      sq_trial;
	logic             q_bit;
	logic [14:0]      q_fin;
	logic [14:0]      q_clip;
	logic [NRM_W-1:0] q_signed;
	logic [ACC_W-1:0] acc_comp [3];
	logic [ACC_W-1:0] mag [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			acc_comp[i] = acc[i*ACC_W +: ACC_W];
			mag[i] = acc_comp[i][ACC_W-1] ? (~acc_comp[i] + ACC_W'(1)) : acc_comp[i];
		end
		mx = m_q[0];
		if (m_q[1] > mx) mx = m_q[1];
		if (m_q[2] > mx) mx = m_q[2];
		mul_op = (k_q == 3'd3) ? 32'(min_len) : m_q[k_q[1:0]][31:0];
		sq_bit = 64'(1) << {j_q, 1'b0};
		sq_trial = r_q + sq_bit;
		q_bit = (rem_q >= 47'(d_q));
		q_fin = {q_q[13:0], q_bit};
		q_clip = (q_fin > 15'(ONE_Q14)) ? 15'(ONE_Q14) : q_fin;
		q_signed = neg_q[c_q] ? (NRM_W'(0) - NRM_W'(q_clip)) : NRM_W'(q_clip);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
			m_q <= '{default: '0};
			neg_q <= '0;
			k_q <= '0;
			prod_q <= '0;
			sum_q <= '0;
			s_q <= '0;
			r_q <= '0;
			j_q <= '0;
			rem_q <= '0;
			d_q <= '0;
			q_q <= '0;
			i_q <= '0;
			c_q <= '0;
			res_q <= FALLBACK;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			prod_q <= 64'(mul_op) * 64'(mul_op);
			unique case (state_q)
				N_IDLE: begin
					if (start) begin
						for (int i = 0; i < 3; i++) begin
							m_q[i] <= mag[i];
							neg_q[i] <= acc_comp[i][ACC_W-1];
						end
						res_q.fallback <= 1'b0;
						state_q <= N_MAX;
					end
				end
				N_MAX: begin
					k_q <= '0;
					sum_q <= '0;
					if (mx == '0) begin
						res_q <= FALLBACK;
						done_q <= 1'b1;
						state_q <= N_IDLE;
					end else if (mx[ACC_W-1:16] == '0) begin
						state_q <= N_THR;
					end else begin
						state_q <= N_SHIFT;
					end
				end
				N_THR: begin
					k_q <= k_q + 3'd1;
					if (k_q != 3'd0 && k_q != 3'd4) sum_q <= sum_q + prod_q;
					if (k_q == 3'd4) begin
						if (sum_q < prod_q) begin
							res_q <= FALLBACK;
							done_q <= 1'b1;
							state_q <= N_IDLE;
						end else begin
							state_q <= N_SHIFT;
						end
					end
				end
				N_SHIFT: begin
					k_q <= '0;
					sum_q <= '0;
					if (mx[ACC_W-1:31] != '0) begin
						for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
					end else if (!mx[30]) begin
						for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] << 1;
					end else begin
						state_q <= N_SUMSQ;
					end
				end
				N_SUMSQ: begin
					k_q <= k_q + 3'd1;
					if (k_q == 3'd1 || k_q == 3'd2) sum_q <= sum_q + prod_q;
					if (k_q == 3'd3) begin
						s_q <= sum_q + prod_q;
						r_q <= '0;
						j_q <= 5'd31;
						state_q <= N_SQRT;
					end
				end
				N_SQRT: begin
					if (s_q >= sq_trial) begin
						s_q <= s_q - sq_trial;
						r_q <= (r_q >> 1) + sq_bit;
					end else begin
						r_q <= r_q >> 1;
					end
					j_q <= j_q - 5'd1;
					if (j_q == '0) begin
						c_q <= '0;
						state_q <= N_DSET;
					end
				end
				N_DSET: begin
					rem_q <= 47'({m_q[c_q][30:0], 14'd0}) + 47'(r_q[31:1]);
					d_q <= {r_q[31:0], 14'd0};
					q_q <= '0;
					i_q <= 4'd14;
					state_q <= N_DIV;
				end
				N_DIV: begin
					if (q_bit) rem_q <= rem_q - 47'(d_q);
					q_q <= q_fin;
					d_q <= d_q >> 1;
					i_q <= i_q - 4'd1;
					if (i_q == '0) begin
						unique case (c_q)
							2'd0:    res_q.nx <= q_signed;
							2'd1:    res_q.ny <= q_signed;
							default: res_q.nz <= q_signed;
						endcase
						if (c_q == 2'd2) begin
							done_q <= 1'b1;
							state_q <= N_IDLE;
						end else begin
							c_q <= c_q + 2'd1;
							state_q <= N_DSET;
						end
					end
				end
				default: state_q <= N_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign res = res_q;

endmodule

// File: dv/tb_vertex_normal_accumulator_unit.sv
// Self-checking testbench of the vertex normal accumulator with its own normal predictor.
module tb_vertex_normal_accumulator_unit;
	import vna_pkg::*;

	localparam int NPTS = MAX_POINTS_DEF;
	localparam int STALL_LIMIT = 8000;
	localparam int DRAIN_CYCLES = 200;
	localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint ACC_LO = -ACC_HI - 1;

	typedef struct {
		logic [1:0]               func;
		logic [IDX_W-1:0]         va, vb, vc;
		logic signed [CRD_W-1:0]  x, y, z;
	} mesh_op_t;

	typedef struct {
		logic [IDX_W-1:0]         idx;
		logic signed [NRM_W-1:0]  nx, ny, nz;
		logic                     fb;
	} normal_beat_t;

	logic clk, arst_n;
	logic cfg_wr_en;
	logic [ML_W-1:0] cfg_wr_data;
	logic s_tvalid, s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic [1:0] s_tuser;
	logic m_tvalid, m_tready;
	logic [M_DATA_W-1:0] m_tdata;
	logic [0:0] m_tuser;

	vertex_normal_accumulator_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	mesh_op_t op_queue[$];
	mesh_op_t cur_op;
	normal_beat_t normal_expect_q[$];
	logic signed [CRD_W-1:0] pt_x[NPTS], pt_y[NPTS], pt_z[NPTS];
	longint acc_x[NPTS], acc_y[NPTS], acc_z[NPTS];
	int unsigned min_len_copy;
	int errors;
	int unsigned cycle_cnt;
	int unsigned idle_cnt;
	int results_seen;
	int hold_left;
	bit hold_done;
	int loaded_q[$];
	bit loaded[NPTS];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint sat_sum(longint a, longint d);
		longint s;
		s = a + d;
		if (s > ACC_HI) return ACC_HI;
		if (s < ACC_LO) return ACC_LO;
		return s;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned s);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > s) b = b >> 2;
		while (b != 0) begin
			if (s >= r + b) begin
				s = s - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic normal_beat_t unit_normal(logic [IDX_W-1:0] v);
		normal_beat_t o;
		longint a[3];
		longint unsigned m[3], mx, s, r, q;
		o.idx = v;
		o.nx = '0; o.ny = ONE_Q14; o.nz = '0; o.fb = 1'b1;
		a[0] = acc_x[v]; a[1] = acc_y[v]; a[2] = acc_z[v];
		mx = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = (a[i] < 0) ? -a[i] : a[i];
			if (m[i] > mx) mx = m[i];
		end
		if (mx == 0) return o;
		if (mx < 65536 && m[0]*m[0] + m[1]*m[1] + m[2]*m[2] <
				longint'(min_len_copy) * longint'(min_len_copy))
			return o;
		while (mx >= (64'd1 << 31)) begin
			mx = mx >> 1;
			for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
		end
		while (mx < (64'd1 << 30)) begin
			mx = mx << 1;
			for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
		end
		s = m[0]*m[0] + m[1]*m[1] + m[2]*m[2];
		r = int_sqrt(s);
		for (int i = 0; i < 3; i++) begin
			q = (m[i] * 16384 + (r >> 1)) / r;
			if (q > 16384) q = 16384;
			if (a[i] < 0) q = -q;
			if (i == 0) o.nx = q[15:0];
			else if (i == 1) o.ny = q[15:0];
			else o.nz = q[15:0];
		end
		o.fb = 1'b0;
		return o;
	endfunction

	task automatic apply_op(mesh_op_t op);
		longint e1[3], e2[3], n[3];
		logic [IDX_W-1:0] c[3];
		if (op.func == FUNC_LOAD) begin
			pt_x[op.va] = op.x; pt_y[op.va] = op.y; pt_z[op.va] = op.z;
			acc_x[op.va] = 0; acc_y[op.va] = 0; acc_z[op.va] = 0;
		end else if (op.func == FUNC_TRI) begin
			e1[0] = pt_x[op.vb] - pt_x[op.va]; e2[0] = pt_x[op.vc] - pt_x[op.va];
			e1[1] = pt_y[op.vb] - pt_y[op.va]; e2[1] = pt_y[op.vc] - pt_y[op.va];
			e1[2] = pt_z[op.vb] - pt_z[op.va]; e2[2] = pt_z[op.vc] - pt_z[op.va];
			n[0] = e1[1]*e2[2] - e1[2]*e2[1];
			n[1] = e1[2]*e2[0] - e1[0]*e2[2];
			n[2] = e1[0]*e2[1] - e1[1]*e2[0];
			c[0] = op.va; c[1] = op.vb; c[2] = op.vc;
			for (int i = 0; i < 3; i++) begin
				acc_x[c[i]] = sat_sum(acc_x[c[i]], n[0]);
				acc_y[c[i]] = sat_sum(acc_y[c[i]], n[1]);
				acc_z[c[i]] = sat_sum(acc_z[c[i]], n[2]);
			end
		end else if (op.func == FUNC_READ) begin
			normal_expect_q.insert(normal_expect_q.size(), unit_normal(op.va));
		end
	endtask

	function automatic mesh_op_t mk_op(logic [1:0] f, int a, int b, int c,
			int x, int y, int z);
		mesh_op_t o;
		o.func = f;
		o.va = IDX_W'(a); o.vb = IDX_W'(b); o.vc = IDX_W'(c);
		o.x = CRD_W'(x); o.y = CRD_W'(y); o.z = CRD_W'(z);
		return o;
	endfunction

	function automatic int pick_coord(int style);
		case (style)
			0: return int'($urandom_range(65535)) - 32768;
			1: return int'($urandom_range(200)) - 100;
			default: return int'($urandom_range(6)) - 3;
		endcase
	endfunction

	function automatic int pick_vertex();
		if ($urandom_range(9) == 0) return $urandom_range(NPTS - 1);
		return $urandom_range(23);
	endfunction

	task automatic add_op(mesh_op_t op);
		op_queue.insert(op_queue.size(), op);
	endtask

	task automatic mark_loaded(int v);
		if (!loaded[v]) begin
			loaded[v] = 1'b1;
			loaded_q.insert(loaded_q.size(), v);
		end
	endtask

	task automatic push_load(int v, int style);
		add_op(mk_op(FUNC_LOAD, v, $urandom_range(1023), $urandom_range(1023),
			pick_coord(style), pick_coord(style), pick_coord(style)));
		mark_loaded(v);
	endtask

	function automatic int pick_loaded();
		if (loaded_q.size() > 24 && $urandom_range(3) != 0)
			return loaded_q[$urandom_range(23)];
		return loaded_q[$urandom_range(loaded_q.size() - 1)];
	endfunction

	task automatic fill_random(int n);
		int r, a, b, c, style;
		style = $urandom_range(2);
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(99);
			if (r < 3)
				style = $urandom_range(2);
			if (r < 25) begin
				push_load(pick_vertex(), style);
			end else if (r < 70) begin
				a = pick_loaded(); b = pick_loaded(); c = pick_loaded();
				if ($urandom_range(19) == 0) b = a;
				add_op(mk_op(FUNC_TRI, a, b, c, pick_coord(0), pick_coord(0),
					pick_coord(0)));
			end else if (r < 96) begin
				add_op(mk_op(FUNC_READ, pick_vertex(), $urandom_range(1023),
					$urandom_range(1023), pick_coord(0), pick_coord(0), pick_coord(0)));
			end else begin
				add_op(mk_op(2'd3, $urandom_range(1023), $urandom_range(1023),
					$urandom_range(1023), pick_coord(0), pick_coord(0), pick_coord(0)));
			end
		end
	endtask

	task automatic drain_and_set(int unsigned v);
		while (op_queue.size() != 0 || s_tvalid || normal_expect_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= ML_W'(v);
		min_len_copy = v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Driver: presents one beat at a time and updates the predictor on each accepted beat.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid)
				apply_op(cur_op);
			if (op_queue.size() != 0 &&
					((cycle_cnt > 20000 && cycle_cnt < 40000) || $urandom_range(99) >= 10)) begin
				cur_op = op_queue.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {2'b00, cur_op.z, cur_op.y, cur_op.x, cur_op.vc, cur_op.vb, cur_op.va};
				s_tuser <= cur_op.func;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Monitor: compares each result beat with the oldest predicted normal.
	always @(posedge clk or negedge arst_n) begin
		normal_beat_t e;
		if (!arst_n) begin
			m_tready <= 1'b0;
			results_seen <= 0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen <= results_seen + 1;
				if (normal_expect_q.size() == 0) begin
					$error("unexpected result beat %h", m_tdata);
					errors++;
				end else begin
					e = normal_expect_q.pop_front();
					if (m_tdata[9:0] !== e.idx) begin
						$error("vertex_index exp %0d got %0d", e.idx, m_tdata[9:0]);
						errors++;
					end
					if (m_tdata[25:10] !== e.nx) begin
						$error("normal_x exp %0d got %0d", e.nx, $signed(m_tdata[25:10]));
						errors++;
					end
					if (m_tdata[41:26] !== e.ny) begin
						$error("normal_y exp %0d got %0d", e.ny, $signed(m_tdata[41:26]));
						errors++;
					end
					if (m_tdata[57:42] !== e.nz) begin
						$error("normal_z exp %0d got %0d", e.nz, $signed(m_tdata[57:42]));
						errors++;
					end
					if (m_tuser[0] !== e.fb) begin
						$error("used_fallback exp %0d got %0d", e.fb, m_tuser[0]);
						errors++;
					end
				end
			end
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_tready <= 1'b0;
			end else if (!hold_done && results_seen == 40) begin
				hold_done <= 1'b1;
				hold_left <= 1500;
				m_tready <= 1'b0;
			end else begin
				m_tready <= (cycle_cnt > 20000 && cycle_cnt < 40000) || $urandom_range(99) >= 10;
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt > STALL_LIMIT) begin
			$display("vertex_normal_accumulator_unit: mismatch");
			$finish;
		end
	end

	initial begin
		errors = 0;
		cycle_cnt = 0;
		idle_cnt = 0;
		min_len_copy = 1;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		for (int i = 0; i < NPTS; i++) begin
			acc_x[i] = 0; acc_y[i] = 0; acc_z[i] = 0;
			pt_x[i] = '0; pt_y[i] = '0; pt_z[i] = '0;
			loaded[i] = 1'b0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		drain_and_set(1);

		// Extremes of coordinates and indices, a degenerate triangle, an unused
		// code and a read of a vertex that has never been loaded.
		add_op(mk_op(FUNC_READ, 1023, 0, 0, 0, 0, 0));
		add_op(mk_op(FUNC_LOAD, 0, 1023, 1023, 32767, -32768, 32767));
		add_op(mk_op(FUNC_LOAD, 1023, 0, 0, -32768, 32767, -32768));
		add_op(mk_op(FUNC_LOAD, 1, 0, 0, -32768, -32768, 32767));
		add_op(mk_op(FUNC_LOAD, 2, 0, 0, 0, 0, 0));
		add_op(mk_op(FUNC_TRI, 0, 1023, 1, 0, 0, 0));
		add_op(mk_op(FUNC_TRI, 0, 0, 1, 0, 0, 0));
		add_op(mk_op(FUNC_TRI, 2, 1, 2, 0, 0, 0));
		add_op(mk_op(FUNC_READ, 0, 0, 0, 0, 0, 0));
		add_op(mk_op(FUNC_READ, 1023, 0, 0, 0, 0, 0));
		add_op(mk_op(FUNC_READ, 1, 0, 0, 0, 0, 0));
		add_op(mk_op(FUNC_READ, 2, 0, 0, 0, 0, 0));
		add_op(mk_op(2'd3, 1023, 1023, 1023, -1, -1, -1));
		add_op(mk_op(FUNC_LOAD, 3, 0, 0, 0, 0, 0));
		add_op(mk_op(FUNC_LOAD, 4, 0, 0, 1, 0, 0));
		add_op(mk_op(FUNC_LOAD, 5, 0, 0, 0, 1, 0));
		add_op(mk_op(FUNC_TRI, 3, 4, 5, 0, 0, 0));
		add_op(mk_op(FUNC_READ, 3, 0, 0, 0, 0, 0));
		add_op(mk_op(FUNC_LOAD, 0, 0, 0, 0, 0, 0));
		add_op(mk_op(FUNC_READ, 0, 0, 0, 0, 0, 0));
		foreach (op_queue[i])
			if (op_queue[i].func == FUNC_LOAD)
				mark_loaded(op_queue[i].va);
		for (int v = 6; v < 24; v++)
			push_load(v, 1);
		fill_random(200);
		drain_and_set(0);
		fill_random(230);
		drain_and_set(65535);
		fill_random(230);
		drain_and_set(300);
		fill_random(230);
		drain_and_set($urandom_range(65535));
		fill_random(230);

		while (op_queue.size() != 0 || s_tvalid || normal_expect_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("vertex_normal_accumulator_unit: match");
		else
			$display("vertex_normal_accumulator_unit: mismatch");
		$finish;
	end

endmodule
